// File: rtl/core/bcd_four_digit_alu_core_assert.svh
// Assertion macros for the BCD ALU core; they sample on clk and hold off during arst_n.
`ifndef BCD_FOUR_DIGIT_ALU_CORE_ASSERT_SVH
`define BCD_FOUR_DIGIT_ALU_CORE_ASSERT_SVH

// Check a same-cycle implication.
`define BCDALU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcd alu assertion failed");

// Check a next-cycle implication.
`define BCDALU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcd alu assertion failed");

`endif

// File: rtl/core/bcdalu_pkg.sv
`default_nettype none
package bcdalu_pkg;

	localparam int DIGITS_DEF = 4;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_NIBBLE  = 2'd1;
	localparam logic [1:0] ERR_OP      = 2'd2;
	localparam logic [1:0] ERR_DIVZERO = 2'd3;

	localparam logic [3:0] SQ_STEPS = 4'd9;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_ADD,
		CMD_SUB,
		CMD_SETUP_AB,
		CMD_MSHIFT,
		CMD_MADD,
		CMD_DIV_INIT,
		CMD_DIV_SHIFT,
		CMD_DIV_TRY,
		CMD_POW_INIT,
		CMD_E_SHIFT,
		CMD_SETUP_PT,
		CMD_SETUP_PA,
		CMD_P_FROM_R,
		CMD_R_FROM_P,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic div;
		logic err;
	} ctl_t;

	typedef struct packed {
		logic bad;
		logic b_zero;
		logic y_top_zero;
		logic e_top_zero;
		logic ge;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/bcdalu_adder.sv
`default_nettype none
module bcdalu_adder #(
	parameter int N = 5
) (
	input  wire logic [4*N-1:0] x,
	input  wire logic [4*N-1:0] y,
	input  wire logic           cin,
	output logic      [4*N-1:0] sum,
	output logic                cout
);
	logic [N:0] c;

	assign c[0] = cin;

	for (genvar i = 0; i < N; i++) begin : g_dig
		logic [4:0] raw;
		logic       hi;
		assign raw = 5'(x[4*i +: 4]) + 5'(y[4*i +: 4]) + 5'(c[i]);
		assign hi = raw > 5'd9;
		// decimal correct: add six past nine
		assign sum[4*i +: 4] = hi ? 4'(raw + 5'd6) : raw[3:0];
		assign c[i+1] = hi;
	end

	assign cout = c[N];
endmodule
`default_nettype wire

// File: rtl/core/bcdalu_dp.sv
`default_nettype none
module bcdalu_dp import bcdalu_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  wire logic              clk,
	input  wire logic [4*DIGITS-1:0] operand_a,
	input  wire logic [4*DIGITS-1:0] operand_b,
	input  wire ctl_t              ctl,
	output sts_t                   sts,
	output logic [4*DIGITS-1:0]    result_digits,
	output logic [4*DIGITS-1:0]    remainder_digits
);
	localparam int W  = 4*DIGITS;
	localparam int WE = 4*(DIGITS+1);

	logic [W-1:0]  a_q, b_q, x_q, p_q, t_q, q_q, res_q, rem_q;
	logic [WE-1:0] r_q, y_q, e_q;
	logic [WE-1:0] add_x, add_y, add_sum, b9;
	logic          add_cin, add_cout;
	logic          bad;

	always_comb begin
		b9  = '0;
		bad = 1'b0;
		for (int i = 0; i <= DIGITS; i++) begin
			if (i < DIGITS) begin
				b9[4*i +: 4] = 4'd9 - b_q[4*i +: 4];
				if (a_q[4*i +: 4] > 4'd9 || b_q[4*i +: 4] > 4'd9)
					bad = 1'b1;
			end else begin
				b9[4*i +: 4] = 4'd9;
			end
		end
	end

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		case (ctl.cmd)
			CMD_ADD: begin
				add_x = {4'd0, a_q};
				add_y = {4'd0, b_q};
			end
			CMD_SUB: begin
				add_x   = {4'd0, a_q};
				add_y   = {4'd0, b9[W-1:0]};
				add_cin = 1'b1;
			end
			CMD_MADD: begin
				add_x = r_q;
				add_y = {4'd0, x_q};
			end
			CMD_DIV_TRY: begin
				add_x   = r_q;
				add_y   = b9;
				add_cin = 1'b1;
			end
			default: begin
				add_cin = 1'b0;
			end
		endcase
	end

	bcdalu_adder #(.N(DIGITS+1)) u_add (
		.x   (add_x),
		.y   (add_y),
		.cin (add_cin),
		.sum (add_sum),
		.cout(add_cout)
	);

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				a_q <= operand_a;
				b_q <= operand_b;
			end
			CMD_ADD, CMD_SUB: r_q <= {4'd0, add_sum[W-1:0]};
			CMD_SETUP_AB: begin
				x_q <= a_q;
				y_q <= {4'd0, b_q};
				r_q <= '0;
			end
			CMD_MSHIFT: begin
				r_q <= {4'd0, W'(r_q << 4)};
				y_q <= y_q << 4;
			end
			CMD_MADD: begin
				r_q <= {4'd0, add_sum[W-1:0]};
				y_q[WE-1 -: 4] <= y_q[WE-1 -: 4] - 4'd1;
			end
			CMD_DIV_INIT: begin
				r_q <= '0;
				q_q <= '0;
				e_q <= {4'd0, a_q};
			end
			CMD_DIV_SHIFT: begin
				r_q <= {r_q[WE-5:0], e_q[W-1 -: 4]};
				e_q <= e_q << 4;
				q_q <= q_q << 4;
			end
			CMD_DIV_TRY: begin
				if (add_cout) begin
					r_q        <= add_sum;
					q_q[3:0]   <= q_q[3:0] + 4'd1;
				end
			end
			CMD_POW_INIT: begin
				p_q <= W'(1);
				e_q <= {4'd0, b_q};
			end
			CMD_E_SHIFT: begin
				e_q <= e_q << 4;
				t_q <= p_q;
			end
			CMD_SETUP_PT: begin
				x_q <= t_q;
				y_q <= {4'd0, p_q};
				r_q <= '0;
			end
			CMD_SETUP_PA: begin
				x_q <= a_q;
				y_q <= {4'd0, p_q};
				r_q <= '0;
				e_q[WE-1 -: 4] <= e_q[WE-1 -: 4] - 4'd1;
			end
			CMD_P_FROM_R: p_q <= r_q[W-1:0];
			CMD_R_FROM_P: r_q <= {4'd0, p_q};
			CMD_FINISH: begin
				res_q <= ctl.err ? '0 : (ctl.div ? q_q : r_q[W-1:0]);
				rem_q <= (ctl.err || !ctl.div) ? '0 : r_q[W-1:0];
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign sts.bad        = bad;
	assign sts.b_zero     = (b_q == '0);
	assign sts.y_top_zero = (y_q[WE-1 -: 4] == 4'd0);
	assign sts.e_top_zero = (e_q[WE-1 -: 4] == 4'd0);
	assign sts.ge         = add_cout;

	assign result_digits    = res_q;
	assign remainder_digits = rem_q;
endmodule
`default_nettype wire

// File: rtl/core/bcdalu_ctrl.sv
`default_nettype none
module bcdalu_ctrl import bcdalu_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [2:0] op,
	input  wire sts_t       sts,
	output ctl_t            ctl,
	output logic            busy,
	output logic            done,
	output logic [1:0]      error_code
);
	localparam int CW = $clog2(DIGITS+1);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_MSHIFT, S_MADD, S_PSHIFT, S_PSQ, S_PA,
		S_DSHIFT, S_DTRY, S_FIN
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q, ecnt_q;
	logic [3:0]  sq_q;
	logic        ret_pow_q;
	logic [2:0]  op_q;
	logic [1:0]  err_q, chk_err;
	logic        done_q;
	logic [1:0]  error_code_q;

	always_comb begin
		if (sts.bad)
			chk_err = ERR_NIBBLE;
		else if (op_q > OP_POW)
			chk_err = ERR_OP;
		else if (op_q == OP_DIV && sts.b_zero)
			chk_err = ERR_DIVZERO;
		else
			chk_err = ERR_OK;
	end

	always_comb begin
		ctl.cmd = CMD_NOP;
		ctl.div = (op_q == OP_DIV);
		ctl.err = (err_q != ERR_OK);
		case (state_q)
			S_IDLE: if (start) ctl.cmd = CMD_LOAD;
			S_CHECK: begin
				if (chk_err == ERR_OK) begin
					case (op_q)
						OP_ADD:  ctl.cmd = CMD_ADD;
						OP_SUB:  ctl.cmd = CMD_SUB;
						OP_MUL:  ctl.cmd = CMD_SETUP_AB;
						OP_DIV:  ctl.cmd = CMD_DIV_INIT;
						OP_POW:  ctl.cmd = CMD_POW_INIT;
						default: ctl.cmd = CMD_NOP;
					endcase
				end
			end
			S_MSHIFT: ctl.cmd = CMD_MSHIFT;
			S_MADD: begin
				if (!sts.y_top_zero)
					ctl.cmd = CMD_MADD;
				else if (cnt_q == '0 && ret_pow_q)
					ctl.cmd = CMD_P_FROM_R;
			end
			S_PSHIFT: ctl.cmd = CMD_E_SHIFT;
			S_PSQ: if (sq_q != 4'd0) ctl.cmd = CMD_SETUP_PT;
			S_PA: begin
				if (!sts.e_top_zero)
					ctl.cmd = CMD_SETUP_PA;
				else if (ecnt_q == '0)
					ctl.cmd = CMD_R_FROM_P;
			end
			S_DSHIFT: ctl.cmd = CMD_DIV_SHIFT;
			S_DTRY:   ctl.cmd = CMD_DIV_TRY;
			S_FIN:    ctl.cmd = CMD_FINISH;
			default:  ctl.cmd = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ecnt_q       <= '0;
			sq_q         <= '0;
			ret_pow_q    <= 1'b0;
			op_q         <= OP_ADD;
			err_q        <= ERR_OK;
			done_q       <= 1'b0;
			error_code_q <= ERR_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					err_q <= chk_err;
					if (chk_err != ERR_OK) begin
						state_q <= S_FIN;
					end else begin
						case (op_q)
							OP_MUL: begin
								cnt_q     <= CW'(DIGITS);
								ret_pow_q <= 1'b0;
								state_q   <= S_MSHIFT;
							end
							OP_DIV: begin
								cnt_q   <= CW'(DIGITS);
								state_q <= S_DSHIFT;
							end
							OP_POW: begin
								ecnt_q  <= CW'(DIGITS);
								state_q <= S_PSHIFT;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_MSHIFT: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_MADD;
				end
				S_MADD: begin
					if (sts.y_top_zero) begin
						if (cnt_q != '0)
							state_q <= S_MSHIFT;
						else if (ret_pow_q)
							state_q <= S_PSQ;
						else
							state_q <= S_FIN;
					end
				end
				S_PSHIFT: begin
					ecnt_q  <= ecnt_q - 1'b1;
					sq_q    <= SQ_STEPS;
					state_q <= S_PSQ;
				end
				S_PSQ: begin
					if (sq_q != 4'd0) begin
						sq_q      <= sq_q - 4'd1;
						cnt_q     <= CW'(DIGITS);
						ret_pow_q <= 1'b1;
						state_q   <= S_MSHIFT;
					end else begin
						state_q <= S_PA;
					end
				end
				S_PA: begin
					if (!sts.e_top_zero) begin
						cnt_q     <= CW'(DIGITS);
						ret_pow_q <= 1'b1;
						state_q   <= S_MSHIFT;
					end else if (ecnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PSHIFT;
					end
				end
				S_DSHIFT: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_DTRY;
				end
				S_DTRY: begin
					if (!sts.ge)
						state_q <= (cnt_q == '0) ? S_FIN : S_DSHIFT;
				end
				S_FIN: begin
					done_q       <= 1'b1;
					error_code_q <= err_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign error_code = error_code_q;
endmodule
`default_nettype wire

// File: rtl/core/bcd_four_digit_alu_core.sv
// Add, subtract and every error pass through the check and finish states to done.
// Multiply shifts once per multiplier digit and adds the multiplicand once per unit of it.
// Divide shifts in one dividend digit at a time and subtracts the divisor until that fails.
// Power raises p to the tenth per exponent digit, then multiplies by a once per unit of it;
// all arithmetic runs on the single shared BCD adder. One word is in flight at a time.
// Reset (arst_n low) clears the controller at once; done is a one-cycle strobe, never stalled.
`default_nettype none
`include "bcd_four_digit_alu_core_assert.svh"
module bcd_four_digit_alu_core import bcdalu_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [4*DIGITS-1:0] operand_a,
	input  wire logic [4*DIGITS-1:0] operand_b,
	input  wire logic [2:0]          op,
	output logic                     done,
	output logic [4*DIGITS-1:0]      result_digits,
	output logic [4*DIGITS-1:0]      remainder_digits,
	output logic [1:0]               error_code
);
	ctl_t ctl;
	sts_t sts;

	// Sequence the word: check, then drive the datapath one micro-step a cycle.
	bcdalu_ctrl #(.DIGITS(DIGITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.sts       (sts),
		.ctl       (ctl),
		.busy      (busy),
		.done      (done),
		.error_code(error_code)
	);

	// Hold operands, accumulator, quotient and power registers; share one adder.
	bcdalu_dp #(.DIGITS(DIGITS)) u_dp (
		.clk             (clk),
		.operand_a       (operand_a),
		.operand_b       (operand_b),
		.ctl             (ctl),
		.sts             (sts),
		.result_digits   (result_digits),
		.remainder_digits(remainder_digits)
	);

	// A finished word lands in idle, so a new word may be taken with done.
	`BCDALU_ASSERT_IMP(a_done_idle, done, !busy)
	// An accepted word always makes the core busy next cycle.
	`BCDALU_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	// Drop both result fields on any error.
	`BCDALU_ASSERT_IMP(a_err_zero, done && (error_code != ERR_OK),
		(result_digits == '0) && (remainder_digits == '0))
endmodule
`default_nettype wire

// File: test/tb_bcd_four_digit_alu_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_bcd_four_digit_alu_core;
	import bcdalu_pkg::*;

	localparam int ND = DIGITS_DEF;
	localparam int W = 4 * ND;
	// The limit covers the longest power word plus sender gaps and margin.
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [W-1:0] quot;
		logic [W-1:0] rem;
		logic [1:0]   err;
	} alu_word_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [W-1:0] operand_a;
	logic [W-1:0] operand_b;
	logic [2:0] op;
	logic done;
	logic [W-1:0] result_digits;
	logic [W-1:0] remainder_digits;
	logic [1:0] error_code;

	alu_word_t expected_words[$];
	int failures;
	int words_sent;
	int words_checked;
	int idle_pct;
	int quiet_cycles;
	int op_hits[8];

	bcd_four_digit_alu_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.op(op),
		.done(done),
		.result_digits(result_digits),
		.remainder_digits(remainder_digits),
		.error_code(error_code)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit bcd_valid(logic [W-1:0] v);
		for (int i = 0; i < ND; i++)
			if (v[4*i +: 4] > 4'd9)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic longint unsigned bcd_value(logic [W-1:0] v);
		longint unsigned acc;
		acc = 0;
		for (int i = ND - 1; i >= 0; i--)
			acc = acc * 10 + v[4*i +: 4];
		return acc;
	endfunction

	function automatic logic [W-1:0] value_bcd(longint unsigned v);
		logic [W-1:0] r;
		r = '0;
		for (int i = 0; i < ND; i++) begin
			r[4*i +: 4] = 4'(v % 10);
			v = v / 10;
		end
		return r;
	endfunction

	// Decimal ALU behavior: all arithmetic modulo 10^ND.
	function automatic alu_word_t compute_alu(logic [W-1:0] a_in, logic [W-1:0] b_in,
			logic [2:0] code);
		alu_word_t w;
		longint unsigned m, a, b, r, base, e;
		m = 1;
		for (int i = 0; i < ND; i++)
			m = m * 10;
		w.quot = '0;
		w.rem = '0;
		w.err = ERR_OK;
		// a bad nibble beats every other error
		if (!bcd_valid(a_in) || !bcd_valid(b_in)) begin
			w.err = ERR_NIBBLE;
			return w;
		end
		a = bcd_value(a_in);
		b = bcd_value(b_in);
		case (code)
			OP_ADD: w.quot = value_bcd((a + b) % m);
			OP_SUB: w.quot = value_bcd((a + m - b) % m);
			OP_MUL: w.quot = value_bcd((a * b) % m);
			OP_DIV: begin
				if (b == 0)
					w.err = ERR_DIVZERO;
				else begin
					w.quot = value_bcd(a / b);
					w.rem = value_bcd(a % b);
				end
			end
			OP_POW: begin
				r = 1 % m;
				base = a;
				e = b;
				while (e != 0) begin
					if (e[0])
						r = (r * base) % m;
					base = (base * base) % m;
					e = e >> 1;
				end
				w.quot = value_bcd(r);
			end
			default: w.err = ERR_OP;
		endcase
		return w;
	endfunction

	function automatic logic [W-1:0] rand_bcd();
		logic [W-1:0] v;
		for (int i = 0; i < ND; i++)
			v[4*i +: 4] = 4'($urandom_range(0, 9));
		return v;
	endfunction

	// Drive one word, hold it until the block takes it, then drop start.
	// Advance at least one falling edge first so start is never driven twice in one step.
	task automatic send_word(logic [W-1:0] a_in, logic [W-1:0] b_in, logic [2:0] code);
		do
			@(negedge clk);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct);
		operand_a <= a_in;
		operand_b <= b_in;
		op <= code;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		expected_words.push_back(compute_alu(a_in, b_in, code));
		words_sent++;
		op_hits[code]++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	// Results arrive as one-cycle done strobes; compare against the oldest expectation.
	always @(posedge clk) begin
		alu_word_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				failures++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (result_digits !== want.quot) begin
					$error("result_digits: expected %h, got %h", want.quot, result_digits);
					failures++;
				end
				if (remainder_digits !== want.rem) begin
					$error("remainder_digits: expected %h, got %h", want.rem,
						remainder_digits);
					failures++;
				end
				if (error_code !== want.err) begin
					$error("error_code: expected %0d, got %0d", want.err, error_code);
					failures++;
				end
			end
		end
	end

	// Watchdog: count cycles with nothing accepted in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else if (expected_words.size() != 0 || start)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_extremes();
		logic [W-1:0] nines;
		nines = value_bcd(9999);
		idle_pct = 0;
		send_word('0, '0, OP_ADD);
		send_word(nines, nines, OP_ADD);
		send_word('0, value_bcd(1), OP_SUB);
		send_word(nines, nines, OP_SUB);
		send_word(nines, nines, OP_MUL);
		send_word(value_bcd(1234), '0, OP_MUL);
		send_word(nines, value_bcd(1), OP_DIV);
		send_word(value_bcd(7), nines, OP_DIV);
		send_word(nines, value_bcd(37), OP_DIV);
		send_word('0, '0, OP_POW);
		send_word(nines, '0, OP_POW);
		send_word(value_bcd(2), value_bcd(13), OP_POW);
		send_word(value_bcd(7), nines, OP_POW);
	endtask

	task automatic test_error_cases();
		idle_pct = 0;
		send_word(value_bcd(42), '0, OP_DIV);
		send_word('0, '0, OP_DIV);
		send_word(16'hFFFF, 16'hFFFF, OP_ADD);
		send_word(16'h000A, value_bcd(1), 3'd5);
		send_word(value_bcd(1), 16'hA000, OP_DIV);
		send_word(value_bcd(5), value_bcd(3), 3'd6);
		send_word(value_bcd(5), value_bcd(3), 3'd7);
		send_word(16'h0F00, '0, OP_DIV);
	endtask

	// Mostly valid operands with every op; a few bad nibbles and bad codes.
	// Power exponents stay small most of the time to keep the run short.
	task automatic test_random(int count, int pct);
		logic [W-1:0] a_in, b_in;
		logic [2:0] code;
		idle_pct = pct;
		repeat (count) begin
			a_in = rand_bcd();
			b_in = rand_bcd();
			code = 3'($urandom_range(0, 4));
			if ($urandom_range(0, 19) == 0)
				code = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 19) == 0)
				a_in = 16'($urandom);
			if ($urandom_range(0, 19) == 0)
				b_in = 16'($urandom);
			if (code == OP_POW && $urandom_range(0, 9) != 0)
				b_in = value_bcd($urandom_range(0, 99));
			if (code == OP_DIV && $urandom_range(0, 4) == 0)
				b_in = value_bcd($urandom_range(0, 9));
			send_word(a_in, b_in, code);
		end
	endtask

	initial begin
		int drain;
		failures = 0;
		words_sent = 0;
		words_checked = 0;
		idle_pct = 0;
		quiet_cycles = 0;
		foreach (op_hits[i])
			op_hits[i] = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operand_a = '0;
		operand_b = '0;
		op = OP_ADD;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_extremes();
		test_error_cases();
		test_random(700, 0);
		test_random(600, 51);
		test_random(700, 7);

		// hold until every word is back, then a short tail for strays
		drain = 0;
		while (expected_words.size() != 0 && drain < 50000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d words, checked %0d results.", words_sent, words_checked);
		$display("Ops add/sub/mul/div/pow: %0d/%0d/%0d/%0d/%0d, bad codes %0d.",
			op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4],
			op_hits[5] + op_hits[6] + op_hits[7]);
		if (failures == 0 && expected_words.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
